// ===== hdl/dssw_pkg.sv =====
// Package for the decimal seven-segment writer.
// Holds the sizing constants, the controller state type and the digit-to-segment table.
// No dependencies.
package dssw_pkg;

	localparam int MAX_DIGITS = 10;
	localparam int VALUE_BITS = 32;

	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 4;
	localparam int ADDR_W      = 8;
	localparam int SEG_W       = 7;
	localparam int BCD_W       = 4;
	localparam int BIT_CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int DIG_IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Segment pattern, bit 6 is segment a and bit 0 is segment g.
	function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] digit);
		logic [SEG_W-1:0] code;
		unique case (digit)
			4'd0:    code = 7'h7E;
			4'd1:    code = 7'h30;
			4'd2:    code = 7'h6D;
			4'd3:    code = 7'h79;
			4'd4:    code = 7'h33;
			4'd5:    code = 7'h5B;
			4'd6:    code = 7'h5F;
			4'd7:    code = 7'h70;
			4'd8:    code = 7'h7F;
			4'd9:    code = 7'h7B;
			default: code = 7'h7E;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/decimal_seven_segment_writer_top.sv =====
// Decimal seven-segment writer, top level.
// Depends on dssw_pkg and dssw_cell.
// An accepted value goes through a chain of ten BCD digit cells, one binary bit per cycle;
// then one display write beat leaves per cycle unless the sink holds out_ready low, most
// significant digit first, addresses counting down from start_position + 1 modulo 256,
// the final beat flagged by last. An item with digit_count zero produces nothing, and
// counts above ten are treated as ten. A new item is taken only once the previous one
// has handed its last beat to the output register.
module decimal_seven_segment_writer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dssw_pkg::VALUE_W-1:0] value,
	input  logic [dssw_pkg::COUNT_W-1:0] digit_count,
	input  logic [dssw_pkg::ADDR_W-1:0]  start_position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dssw_pkg::ADDR_W-1:0]  reg_address,
	output logic [dssw_pkg::SEG_W-1:0]   segment_code,
	output logic                        last
);
	import dssw_pkg::*;

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] shift_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  out_valid_q;
	logic [ADDR_W-1:0]     reg_address_q;
	logic [SEG_W-1:0]      segment_code_q;
	logic                  last_q;

	logic                  accept;
	logic                  shift_en;
	logic                  load_out;
	logic [COUNT_W-1:0]    count_sat;
	logic [MAX_DIGITS:0]   carry;
	logic [BCD_W-1:0]      digits [MAX_DIGITS];

	assign count_sat = (digit_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : digit_count;
	assign accept    = in_valid && in_ready;

	// The chain is fed from the top bit of the value; the carry out of the top cell is
	// dropped, which discards any digits above the chain.
	assign carry[0] = shift_q[VALUE_BITS-1];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		dssw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (accept),
			.shift_en (shift_en),
			.bit_in   (carry[i]),
			.bit_out  (carry[i+1]),
			.digit    (digits[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (digit_count != '0)) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out && (idx_q == '0)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CONV: shift_en = 1'b1;
			ST_EMIT: load_out = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			idx_q     <= '0;
			addr_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_cnt_q <= '0;
				idx_q     <= DIG_IDX_W'(count_sat - COUNT_W'(1));
				addr_q    <= start_position + ADDR_W'(1);
			end else begin
				if (shift_en) bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				if (load_out) begin
					idx_q  <= idx_q - DIG_IDX_W'(1);
					addr_q <= addr_q - ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q <= value[VALUE_BITS-1:0];
		end else if (shift_en) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Output register: one beat held until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			reg_address_q  <= addr_q;
			segment_code_q <= seg_code(digits[idx_q]);
			last_q         <= (idx_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign reg_address  = reg_address_q;
	assign segment_code = segment_code_q;
	assign last         = last_q;

endmodule

// ===== hdl/dssw_cell.sv =====
// One decimal digit cell of the shift-and-add-3 binary to BCD converter.
// Depends on dssw_pkg for the digit width.
module dssw_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      shift_en,
	input  logic                      bit_in,
	output logic                      bit_out,
	output logic [dssw_pkg::BCD_W-1:0] digit
);
	import dssw_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	// A digit of five or more gets three added so that the doubling carries into the next cell.
	assign adj     = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
	assign bit_out = adj[BCD_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clear) begin
			digit_q <= '0;
		end else if (shift_en) begin
			digit_q <= {adj[BCD_W-2:0], bit_in};
		end
	end

endmodule
